/* rtl/core/esi_pkg.sv */
// Package: shared constants, types and state codes of the eased scroll interpolator.
`timescale 1ns / 1ps

package esi_pkg;

    localparam int POS_W  = 24;
    localparam int TIME_W = 32;
    localparam int DUR_W  = 16;
    localparam int STEP_W = 16;
    localparam int PROG_W = 16;
    localparam int BASE_W = 17;
    localparam int EASE_W = 17;
    localparam int DIFF_W = POS_W + 1;
    localparam int ACC_W  = 2 * BASE_W + BASE_W;
    localparam int CNT_W  = 5;

    localparam int DIV_STEPS = PROG_W;
    localparam int MUL_STEPS = BASE_W;

    localparam logic [DUR_W-1:0]  DURATION_RESET = 16'd300;
    localparam logic [EASE_W-1:0] EASE_ONE       = 17'd65536;
    localparam logic [BASE_W-1:0] BASE_TWO       = 17'd0;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SQR_LD,
        S_SQR,
        S_CUBE_LD,
        S_CUBE,
        S_MIX_LD,
        S_MIX,
        S_FIN,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic sqr_load;
        logic cube_load;
        logic mix_load;
        logic mul_step;
        logic fin;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_calc;
    } t_dp_sts;

endpackage

/* rtl/core/esi_in_if.sv */
// Interface: input request channel (op, positions, time step).
`timescale 1ns / 1ps

interface esi_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [esi_pkg::POS_W-1:0]    start_pos;
    logic signed [esi_pkg::POS_W-1:0]    finish_pos;
    logic        [esi_pkg::STEP_W-1:0]   time_step;

    modport source (output valid, output op, output start_pos, output finish_pos,
                    output time_step, input ready);
    modport sink   (input valid, input op, input start_pos, input finish_pos,
                    input time_step, output ready);
endinterface

/* rtl/core/esi_out_if.sv */
// Interface: result channel (position, done flag).
`timescale 1ns / 1ps

interface esi_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [esi_pkg::POS_W-1:0] position;
    logic                             done_res;

    modport source (output valid, output position, output done_res, input ready);
    modport sink   (input valid, input position, input done_res, output ready);
endinterface

/* rtl/core/esi_datapath.sv */
// Datapath: animation state, restoring divider, shift-add multiplier, output register.
`timescale 1ns / 1ps

module esi_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  esi_pkg::t_dp_cmd                    i_cmd,
    output esi_pkg::t_dp_sts                    o_sts,
    input  logic                                i_op,
    input  logic signed [esi_pkg::POS_W-1:0]    i_start_pos,
    input  logic signed [esi_pkg::POS_W-1:0]    i_finish_pos,
    input  logic        [esi_pkg::STEP_W-1:0]   i_time_step,
    input  logic                                i_cfg_we,
    input  logic        [esi_pkg::DUR_W-1:0]    i_cfg_data,
    output logic signed [esi_pkg::POS_W-1:0]    o_position,
    output logic                                o_done_res
);

    logic        [esi_pkg::DUR_W-1:0]   r_duration;
    logic signed [esi_pkg::POS_W-1:0]   r_origin;
    logic signed [esi_pkg::POS_W-1:0]   r_goal;
    logic signed [esi_pkg::POS_W-1:0]   r_present;
    logic        [esi_pkg::TIME_W-1:0]  r_time;
    logic                               r_finished;

    logic        [esi_pkg::DUR_W-1:0]   r_rem;
    logic        [esi_pkg::PROG_W-1:0]  r_dlow;
    logic        [esi_pkg::PROG_W-1:0]  r_quo;
    logic        [esi_pkg::BASE_W-1:0]  r_base;
    logic                               r_hi;
    logic        [esi_pkg::ACC_W-1:0]   r_acc;
    logic        [esi_pkg::ACC_W-1:0]   r_mcand;
    logic        [esi_pkg::BASE_W-1:0]  r_mplier;

    logic signed [esi_pkg::POS_W-1:0]   r_pos_out;
    logic                               r_done_out;

    logic [esi_pkg::TIME_W:0]           w_sum;
    logic [esi_pkg::TIME_W-1:0]         w_t;
    logic [esi_pkg::TIME_W-1:0]         w_limit;
    logic                               w_step_run;
    logic [esi_pkg::DUR_W:0]            w_shifted;
    logic [esi_pkg::DUR_W:0]            w_trial;
    logic [esi_pkg::BASE_W-1:0]         w_base;
    logic [esi_pkg::EASE_W-1:0]         w_ease;
    logic [esi_pkg::DIFF_W-1:0]         w_diff;

    always_comb begin
        w_sum      = {1'b0, r_time} + (esi_pkg::TIME_W + 1)'(i_time_step);
        w_t        = w_sum[esi_pkg::TIME_W] ? '1 : w_sum[esi_pkg::TIME_W-1:0];
        w_limit    = {8'd0, r_duration, 8'd0};
        w_step_run = (i_op == esi_pkg::OP_STEP) && !r_finished;
        o_sts.need_calc = w_step_run && (w_t < w_limit);

        w_shifted = {r_rem, r_dlow[esi_pkg::PROG_W-1]};
        w_trial   = w_shifted - {1'b0, r_duration};

        // upper half of the curve mirrors: g = 2 - 2p in Q1.16
        if (r_quo[esi_pkg::PROG_W-1]) begin
            w_base = esi_pkg::BASE_TWO - {r_quo, 1'b0};
        end else begin
            w_base = {1'b0, r_quo};
        end

        if (r_hi) begin
            w_ease = esi_pkg::EASE_ONE - {1'b0, r_acc[48:33]};
        end else begin
            w_ease = {2'd0, r_acc[44:30]};
        end

        w_diff = {r_goal[esi_pkg::POS_W-1], r_goal} - {r_origin[esi_pkg::POS_W-1], r_origin};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= esi_pkg::DURATION_RESET;
            r_origin   <= '0;
            r_goal     <= '0;
            r_present  <= '0;
            r_time     <= '0;
            r_finished <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_duration <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (i_op == esi_pkg::OP_START) begin
                    r_origin   <= i_start_pos;
                    r_goal     <= i_finish_pos;
                    r_present  <= i_start_pos;
                    r_time     <= '0;
                    r_finished <= 1'b0;
                end else if (w_step_run) begin
                    r_time <= w_t;
                    if (w_t >= w_limit) begin
                        r_present  <= r_goal;
                        r_finished <= 1'b1;
                    end
                end
            end
            if (i_cmd.fin) begin
                // floor shift of the product: arithmetic bits 39..16 suffice modulo 2^24
                r_present <= r_origin + r_acc[39:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rem  <= w_t[23:8];
            r_dlow <= {w_t[7:0], 8'd0};
            r_quo  <= '0;
        end
        if (i_cmd.div_step) begin
            r_dlow <= {r_dlow[esi_pkg::PROG_W-2:0], 1'b0};
            if (!w_trial[esi_pkg::DUR_W]) begin
                r_rem <= w_trial[esi_pkg::DUR_W-1:0];
                r_quo <= {r_quo[esi_pkg::PROG_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shifted[esi_pkg::DUR_W-1:0];
                r_quo <= {r_quo[esi_pkg::PROG_W-2:0], 1'b0};
            end
        end
        if (i_cmd.sqr_load) begin
            r_base   <= w_base;
            r_hi     <= r_quo[esi_pkg::PROG_W-1];
            r_mcand  <= esi_pkg::ACC_W'(w_base);
            r_mplier <= w_base;
            r_acc    <= '0;
        end
        if (i_cmd.cube_load) begin
            r_mcand  <= r_acc;
            r_mplier <= r_base;
            r_acc    <= '0;
        end
        if (i_cmd.mix_load) begin
            r_mcand  <= {{(esi_pkg::ACC_W - esi_pkg::DIFF_W){w_diff[esi_pkg::DIFF_W-1]}}, w_diff};
            r_mplier <= w_ease;
            r_acc    <= '0;
        end
        if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[esi_pkg::ACC_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[esi_pkg::BASE_W-1:1]};
        end
        if (i_cmd.out_load) begin
            r_pos_out  <= r_present;
            r_done_out <= r_finished;
        end
    end

    assign o_position = r_pos_out;
    assign o_done_res = r_done_out;

endmodule

/* rtl/core/esi_ctrl.sv */
// Controller: sequences division, three multiplications and the result handoff.
`timescale 1ns / 1ps

module esi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  esi_pkg::t_dp_sts  i_sts,
    output esi_pkg::t_dp_cmd  o_cmd
);

    esi_pkg::t_state           r_state, n_state;
    logic [esi_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    logic                      w_div_last;
    logic                      w_mul_last;

    assign w_div_last = (r_cnt == esi_pkg::CNT_W'(esi_pkg::DIV_STEPS - 1));
    assign w_mul_last = (r_cnt == esi_pkg::CNT_W'(esi_pkg::MUL_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esi_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            esi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_state      = i_sts.need_calc ? esi_pkg::S_DIV : esi_pkg::S_PUSH;
                end
            end
            esi_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (w_div_last) begin
                    n_cnt   = '0;
                    n_state = esi_pkg::S_SQR_LD;
                end
            end
            esi_pkg::S_SQR_LD: begin
                o_cmd.sqr_load = 1'b1;
                n_state        = esi_pkg::S_SQR;
            end
            esi_pkg::S_SQR: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (w_mul_last) begin
                    n_cnt   = '0;
                    n_state = esi_pkg::S_CUBE_LD;
                end
            end
            esi_pkg::S_CUBE_LD: begin
                o_cmd.cube_load = 1'b1;
                n_state         = esi_pkg::S_CUBE;
            end
            esi_pkg::S_CUBE: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (w_mul_last) begin
                    n_cnt   = '0;
                    n_state = esi_pkg::S_MIX_LD;
                end
            end
            esi_pkg::S_MIX_LD: begin
                o_cmd.mix_load = 1'b1;
                n_state        = esi_pkg::S_MIX;
            end
            esi_pkg::S_MIX: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (w_mul_last) begin
                    n_cnt   = '0;
                    n_state = esi_pkg::S_FIN;
                end
            end
            esi_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = esi_pkg::S_PUSH;
            end
            esi_pkg::S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = esi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = esi_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/eased_scroll_interpolator_core.sv */
// Top level: eased scroll interpolator core, controller plus datapath.
`timescale 1ns / 1ps

// Animates a Q16.8 position from start to target along a cubic ease-in-out curve over
// the programmed duration (whole ms, reset 300). Start requests and step requests that
// finish or find the animation idle skip the arithmetic and go from acceptance straight
// to the result push. A step that lands inside the animation runs the bit-serial
// progress divider, then three passes of one shared shift-add multiplier (square,
// cube, scale of the span), each after its load state, then a finish state. Results
// are held in an output register, so a new request is taken while the previous
// result waits. Write the duration only while no request is in flight.

module eased_scroll_interpolator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    esi_in_if.sink                          i_in,
    esi_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [esi_pkg::DUR_W-1:0]       i_cfg_data
);

    esi_pkg::t_dp_cmd w_cmd;
    esi_pkg::t_dp_sts w_sts;

    esi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    esi_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (i_in.op),
        .i_start_pos  (i_in.start_pos),
        .i_finish_pos (i_in.finish_pos),
        .i_time_step  (i_in.time_step),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_position   (o_out.position),
        .o_done_res   (o_out.done_res)
    );

endmodule

/* tb/esi_result_checker.sv */
// Checker: predicts eased scroll positions from observed requests and compares results.
`timescale 1ns / 1ps

module esi_result_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    esi_in_if                         i_req,
    esi_out_if                        i_res,
    input  logic                      i_cfg_we,
    input  logic [esi_pkg::DUR_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    import esi_pkg::*;

    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    done_res;
    } t_scroll_result;

    logic [DUR_W-1:0]         anim_duration;
    logic signed [POS_W-1:0]  origin_pos;
    logic signed [POS_W-1:0]  goal_pos;
    logic signed [POS_W-1:0]  shown_pos;
    logic [TIME_W-1:0]        elapsed_q24_8;
    logic                     anim_done;
    t_scroll_result           expected_positions[$];
    int                       mismatches;

    function automatic logic [EASE_W-1:0] cubic_ease(input logic [PROG_W-1:0] prog);
        logic [63:0] cube;
        logic [63:0] g;
        if (prog < 16'd32768) begin
            cube = 64'(prog) * 64'(prog) * 64'(prog) * 64'd4;
            return EASE_W'(cube >> 32);
        end
        g = 64'd131072 - 64'd2 * 64'(prog);
        cube = g * g * g;
        return EASE_ONE - EASE_W'(cube >> 33);
    endfunction

    task automatic advance_animation(input logic op, input logic signed [POS_W-1:0] sp,
                                     input logic signed [POS_W-1:0] tp,
                                     input logic [STEP_W-1:0] ts);
        logic [TIME_W:0]           t;
        logic [TIME_W+7:0]         quotient;
        logic [PROG_W-1:0]         prog;
        logic signed [DIFF_W:0]    span;
        logic signed [47:0]        prod;
        logic signed [47:0]        offset;
        t_scroll_result            res;
        if (op == OP_START) begin
            origin_pos    = sp;
            goal_pos      = tp;
            shown_pos     = sp;
            elapsed_q24_8 = '0;
            anim_done     = 1'b0;
        end else if (!anim_done) begin
            t = {1'b0, elapsed_q24_8} + (TIME_W+1)'(ts);
            if (t[TIME_W])
                t = {1'b0, {TIME_W{1'b1}}};
            elapsed_q24_8 = t[TIME_W-1:0];
            if (t >= {9'd0, anim_duration, 8'd0}) begin
                shown_pos = goal_pos;
                anim_done = 1'b1;
            end else begin
                quotient = {t[TIME_W-1:0], 8'd0} / (TIME_W+8)'(anim_duration);
                prog     = (quotient > 40'd65535) ? 16'hFFFF : quotient[PROG_W-1:0];
                span     = goal_pos - origin_pos;
                prod     = span * $signed({1'b0, cubic_ease(prog)});
                offset   = prod >>> 16;
                shown_pos = origin_pos + offset[POS_W-1:0];
            end
        end
        res.position = shown_pos;
        res.done_res = anim_done;
        expected_positions.push_back(res);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_scroll_result want;
        if (!i_rst_n) begin
            anim_duration = DURATION_RESET;
            origin_pos    = '0;
            goal_pos      = '0;
            shown_pos     = '0;
            elapsed_q24_8 = '0;
            anim_done     = 1'b1;
            mismatches    = 0;
            expected_positions.delete();
        end else begin
            if (i_cfg_we)
                anim_duration = i_cfg_data;
            if (i_req.valid && i_req.ready)
                advance_animation(i_req.op, i_req.start_pos, i_req.finish_pos,
                                  i_req.time_step);
            if (i_res.valid && i_res.ready) begin
                if (expected_positions.size() == 0) begin
                    note_mismatch($sformatf("unexpected result position %0d done %0b",
                                            $signed(i_res.position), i_res.done_res));
                end else begin
                    want = expected_positions.pop_front();
                    if (want.position !== i_res.position || want.done_res !== i_res.done_res)
                        note_mismatch($sformatf(
                            "position exp %0d got %0d, done exp %0b got %0b",
                            $signed(want.position), $signed(i_res.position),
                            want.done_res, i_res.done_res));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_positions.size();
    end

endmodule

/* tb/testbench.sv */
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
    import esi_pkg::*;

    localparam int ITEMS          = 1600;
    localparam int PHASES         = 7;
    localparam int IDLE_PCT       = 18;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 5000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [DUR_W-1:0]  cfg_data;
    logic              calm;
    logic              hold_go;
    logic [DUR_W-1:0]  duration_now;
    int                fail_count;
    int                pending;

    esi_in_if  req_if ();
    esi_out_if res_if ();

    eased_scroll_interpolator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    esi_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go)
                hold_left = HOLD_CYCLES;
            else if (hold_left > 0)
                hold_left--;
            res_if.ready <= (hold_left == 0) && !hold_go &&
                            (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic push_req(input logic op, input logic [POS_W-1:0] sp,
                            input logic [POS_W-1:0] tp, input logic [STEP_W-1:0] ts);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.start_pos  <= sp;
        req_if.finish_pos <= tp;
        req_if.time_step  <= ts;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    task automatic start_anim(input logic [POS_W-1:0] sp, input logic [POS_W-1:0] tp);
        push_req(OP_START, sp, tp, STEP_W'($urandom));
    endtask

    task automatic step_anim(input logic [STEP_W-1:0] ts);
        push_req(OP_STEP, POS_W'($urandom), POS_W'($urandom), ts);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_duration(input logic [DUR_W-1:0] d, input logic hold);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= d;
        hold_go  <= hold;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        hold_go  <= 1'b0;
        duration_now = d;
    endtask

    function automatic logic [POS_W-1:0] pick_pos();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 24'h7FFFFF;
        if (roll < 16)
            return 24'h800000;
        return POS_W'($urandom);
    endfunction

    // mostly steps sized so an animation ends in a handful of requests
    function automatic logic [STEP_W-1:0] pick_step();
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(99);
        span = (int'(duration_now) * 256) / 6;
        if (span > 65535)
            span = 65535;
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        if (roll < 20)
            return STEP_W'($urandom);
        return STEP_W'($urandom_range(span));
    endfunction

    function automatic logic [DUR_W-1:0] phase_duration(input int phase);
        case (phase)
            0:       return 16'hFFFF;
            1:       return 16'd1;
            2:       return DUR_W'($urandom_range(1000, 2));
            3:       return DURATION_RESET;
            4:       return DUR_W'($urandom_range(65535, 1));
            5:       return 16'hFFFF;
            default: return DUR_W'($urandom_range(20, 2));
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int steps;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        calm              = 1'b0;
        hold_go           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.op         = OP_START;
        req_if.start_pos  = '0;
        req_if.finish_pos = '0;
        req_if.time_step  = '0;
        duration_now      = DURATION_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // step with nothing running, then the halfway point and the exact end
        step_anim(16'hFFFF);
        start_anim(24'h7FFFFF, 24'h800000);
        step_anim(16'd0);
        step_anim(16'd38400);
        step_anim(16'd256);
        step_anim(16'hFFFF);
        step_anim(16'h1234);
        start_anim(24'h800000, 24'h7FFFFF);
        step_anim(16'hFFFF);
        step_anim(16'd11264);
        step_anim(16'd1);
        start_anim(24'h000100, 24'h000100);
        step_anim(16'h8000);
        start_anim(24'h123456, 24'hFEDCBA);
        start_anim(24'h000000, 24'hFFFFFF);
        step_anim(16'h5555);
        // new duration takes effect on a running animation
        set_duration(16'd1, 1'b0);
        step_anim(16'd0);
        start_anim(24'hFFFFFF, 24'h000001);
        step_anim(16'd255);
        step_anim(16'd1);
        set_duration(16'hFFFF, 1'b0);
        start_anim(24'h7FFFFF, 24'h800000);
        step_anim(16'hFFFF);
        step_anim(16'h00FF);

        for (int phase = 0; phase < PHASES; phase++) begin
            set_duration(phase_duration(phase), phase == 2);
            calm <= (phase == 3);
            sent = 0;
            while (sent < ITEMS / PHASES) begin
                if ($urandom_range(99) < 80) begin
                    start_anim(pick_pos(), pick_pos());
                    steps = $urandom_range(12, 1);
                    for (int k = 0; k < steps; k++)
                        step_anim(pick_step());
                    sent += steps + 1;
                end else begin
                    push_req(1'($urandom), POS_W'($urandom), POS_W'($urandom),
                             STEP_W'($urandom));
                    sent++;
                end
            end
        end
        calm <= 1'b0;
        wait_idle();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/core/esi_pkg.sv
rtl/core/esi_in_if.sv
rtl/core/esi_out_if.sv
rtl/core/esi_datapath.sv
rtl/core/esi_ctrl.sv
rtl/core/eased_scroll_interpolator_core.sv
tb/esi_result_checker.sv
tb/testbench.sv
